// ===== src/odo_pkg.sv =====
// Shared constants, types and the arctangent table for the odometry unit.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package odo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W        = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [31:0] PI_FX      = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_FX  = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_FX = 32'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

    localparam logic [31:0] STEP_RST = 32'd152266;
    localparam logic [31:0] GAIN_RST = 32'd31011737;

    typedef enum logic {
        CFG_STEP = 1'b0,
        CFG_GAIN = 1'b1
    } cfg_idx_t;

    // cos and sin as sign and magnitude, Q2.30
    typedef struct packed {
        logic        c_neg;
        logic [31:0] c_mag;
        logic        s_neg;
        logic [31:0] s_mag;
    } trig_t;

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/odo_dist_mul.sv =====
// Two bit-serial 32x17 shift-add multipliers: travel and turn magnitudes.
// Depends on odo_pkg.
`default_nettype none
module odo_dist_mul
    import odo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] step_distance,
    input  wire logic [31:0] turn_gain,
    input  wire logic [16:0] sum_mag,
    input  wire logic [16:0] diff_mag,
    output logic             busy,
    output logic [48:0]      dist_mag,
    output logic [48:0]      turn_mag
);

    logic [48:0] pd_reg, pd_next, pt_reg, pt_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] sd, st;

    always_comb
    begin
        sd = {1'b0, pd_reg[48:17]} + (pd_reg[0] ? {1'b0, step_distance} : 33'd0);
        st = {1'b0, pt_reg[48:17]} + (pt_reg[0] ? {1'b0, turn_gain} : 33'd0);
        pd_next = {sd, pd_reg[16:1]};
        pt_next = {st, pt_reg[16:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pd_reg <= {32'd0, sum_mag};
            pt_reg <= {32'd0, diff_mag};
        end
        else if (busy_reg)
        begin
            pd_reg <= pd_next;
            pt_reg <= pt_next;
        end
    end

    assign busy     = busy_reg;
    assign dist_mag = pd_reg;
    assign turn_mag = pt_reg;

endmodule
`default_nettype wire

// ===== src/odo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on odo_pkg.
`default_nettype none
module odo_cordic
    import odo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] theta,
    output logic                    busy,
    output trig_t                   trig
);

    logic signed [33:0] x_reg, y_reg, z_reg, xs, ys;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, flip_reg;
    logic signed [31:0] th;
    logic               fl;
    logic signed [33:0] cx, cy, ax, ay;
    logic [4:0]         idx;

    assign idx = 5'(cnt_reg);
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;

    // fold into [-pi/2, pi/2]
    always_comb
    begin
        th = theta;
        fl = 1'b0;
        if (theta > HALF_PI_FX)
        begin
            th = theta - PI_FX;
            fl = 1'b1;
        end
        else if (theta < -HALF_PI_FX)
        begin
            th = theta + PI_FX;
            fl = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= {{2{th[31]}}, th} <<< 2;
            flip_reg <= fl;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - $signed({4'd0, atan_lut(idx)});
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + $signed({4'd0, atan_lut(idx)});
            end
        end
    end

    always_comb
    begin
        cx = flip_reg ? -x_reg : x_reg;
        cy = flip_reg ? -y_reg : y_reg;
        ax = cx[33] ? -cx : cx;
        ay = cy[33] ? -cy : cy;
        trig.c_neg = cx[33];
        trig.c_mag = ax[31:0];
        trig.s_neg = cy[33];
        trig.s_mag = ay[31:0];
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

// ===== src/odo_proj_mul.sv =====
// Bit-serial 49x32 shift-add multipliers projecting travel onto cos and sin.
// Depends on odo_pkg.
`default_nettype none
module odo_proj_mul
    import odo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [48:0] dist_mag,
    input  wire trig_t       trig,
    output logic             busy,
    output logic [80:0]      prod_x,
    output logic [80:0]      prod_y
);

    logic [80:0] px_reg, py_reg;
    logic [49:0] sx, sy;
    logic [4:0]  cnt_reg;
    logic        busy_reg;

    assign sx = {1'b0, px_reg[80:32]} + (px_reg[0] ? {1'b0, dist_mag} : 50'd0);
    assign sy = {1'b0, py_reg[80:32]} + (py_reg[0] ? {1'b0, dist_mag} : 50'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg <= {49'd0, trig.c_mag};
            py_reg <= {49'd0, trig.s_mag};
        end
        else if (busy_reg)
        begin
            px_reg <= {sx, px_reg[31:1]};
            py_reg <= {sy, py_reg[31:1]};
        end
    end

    assign busy   = busy_reg;
    assign prod_x = px_reg;
    assign prod_y = py_reg;

endmodule
`default_nettype wire

// ===== src/differential_drive_odometry_unit.sv =====
// Differential-drive wheel odometry: pose update per encoder poll.
// Depends on odo_pkg, odo_dist_mul, odo_cordic, odo_proj_mul.
//
// Use:
//   s_* stream: one encoder poll per transfer, left and right step deltas.
//   m_* stream: one pose (x, y, heading) per poll, in poll order.
//   cfg_we/cfg_addr/cfg_data: step_distance (0) and turn_gain (1); write
//     only while the block is idle.
// Operation:
//   the CORDIC runs CORDIC_STEPS iterations beside the travel and turn
//   multipliers, then a bit-serial multiply projects the travel on cos and
//   sin, then the pose is updated. One poll is in work at a time;
//   s_tready is high only while idle.
// Reset: pose is zeroed, registers take their default values, no output.
// Stall: a finished pose sits in the output register; the next poll is
//   accepted and worked on, and its pose is committed once that register
//   is free.
`default_nettype none
module differential_drive_odometry_unit
    import odo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [15:0] left_delta, [31:16] right_delta
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [47:0] pos_x, [95:48] pos_y,
                                         // [126:96] heading, [127] zero
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [31:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_PROJ = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] step_reg, gain_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [31:0] head_reg;
    logic sum_neg_reg, diff_neg_reg, xneg_reg, yneg_reg;
    logic signed [30:0] inc_reg;
    logic m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    logic accept, calc_done, commit;
    logic signed [16:0] sum, diff;
    logic [16:0] sum_mag, diff_mag;

    logic dmul_busy, cordic_busy, pmul_busy;
    logic [48:0] dist_mag, turn_mag;
    trig_t trig;
    logic [80:0] prod_x, prod_y;

    // turn increment: round, clamp to pi
    logic [49:0] trnd;
    logic [41:0] tmag;
    logic [29:0] tclamp;
    logic signed [30:0] inc_next;

    // position and heading update
    logic [44:0] rxs, rys;
    logic signed [49:0] dx, dy, nx, ny;
    logic signed [47:0] x_next, y_next;
    logic signed [32:0] h;
    logic signed [31:0] head_next;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign calc_done = (state_reg == ST_CALC) && !dmul_busy && !cordic_busy;
    assign commit    = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        sum      = $signed({s_tdata[15], s_tdata[15:0]}) + $signed({s_tdata[31], s_tdata[31:16]});
        diff     = $signed({s_tdata[15], s_tdata[15:0]}) - $signed({s_tdata[31], s_tdata[31:16]});
        sum_mag  = sum[16] ? 17'(-sum) : sum;
        diff_mag = diff[16] ? 17'(-diff) : diff;
    end

    odo_dist_mul u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .step_distance (step_reg),
        .turn_gain     (gain_reg),
        .sum_mag       (sum_mag),
        .diff_mag      (diff_mag),
        .busy          (dmul_busy),
        .dist_mag      (dist_mag),
        .turn_mag      (turn_mag)
    );

    odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .theta (head_reg),
        .busy  (cordic_busy),
        .trig  (trig)
    );

    odo_proj_mul u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (calc_done),
        .dist_mag (dist_mag),
        .trig     (trig),
        .busy     (pmul_busy),
        .prod_x   (prod_x),
        .prod_y   (prod_y)
    );

    always_comb
    begin
        trnd     = {1'b0, turn_mag} + 50'd128;
        tmag     = trnd[49:8];
        tclamp   = (tmag > 42'(PI_FX)) ? PI_FX[29:0] : tmag[29:0];
        inc_next = diff_neg_reg ? -$signed({1'b0, tclamp}) : $signed({1'b0, tclamp});
    end

    always_comb
    begin
        // (p + 2^37) >> 38, done on the upper bits
        rxs = {1'b0, prod_x[80:37]} + 45'd1;
        rys = {1'b0, prod_y[80:37]} + 45'd1;
        dx  = xneg_reg ? -$signed({6'd0, rxs[44:1]}) : $signed({6'd0, rxs[44:1]});
        dy  = yneg_reg ? -$signed({6'd0, rys[44:1]}) : $signed({6'd0, rys[44:1]});
        nx  = 50'(x_reg) + dx;
        ny  = 50'(y_reg) + dy;
        if (nx > POS_MAX)
            x_next = POS_MAX[47:0];
        else if (nx < POS_MIN)
            x_next = POS_MIN[47:0];
        else
            x_next = nx[47:0];
        if (ny > POS_MAX)
            y_next = POS_MAX[47:0];
        else if (ny < POS_MIN)
            y_next = POS_MIN[47:0];
        else
            y_next = ny[47:0];

        // single wrap into (-pi, pi]
        h = 33'(head_reg) + 33'(inc_reg);
        if (h > 33'(PI_FX))
            head_next = 32'(h - 33'(TWO_PI_FX));
        else if (h <= -33'(PI_FX))
            head_next = 32'(h + 33'(TWO_PI_FX));
        else
            head_next = h[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: if (calc_done) state_next = ST_PROJ;
            ST_PROJ: if (!pmul_busy) state_next = ST_UPD;
            ST_UPD:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_RST;
            gain_reg     <= GAIN_RST;
            x_reg        <= '0;
            y_reg        <= '0;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_STEP: step_reg <= cfg_data;
                    CFG_GAIN: gain_reg <= cfg_data;
                    default:  ;
                endcase
            end
            if (commit)
            begin
                x_reg        <= x_next;
                y_reg        <= y_next;
                head_reg     <= head_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_neg_reg  <= sum[16];
            diff_neg_reg <= diff[16];
        end
        if (calc_done)
        begin
            inc_reg  <= inc_next;
            xneg_reg <= sum_neg_reg ^ trig.c_neg;
            yneg_reg <= sum_neg_reg ^ trig.s_neg;
        end
        if (commit)
            m_tdata_reg <= {1'b0, head_next[30:0], y_next, x_next};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= PI_FX) && (head_reg > -PI_FX))
        else $error("heading left (-pi, pi]");
    a_proj_after_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        !(pmul_busy && (cordic_busy || dmul_busy)))
        else $error("projection overlaps CORDIC or travel multiply");
    a_accept_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !dmul_busy && !cordic_busy && !pmul_busy)
        else $error("poll accepted while a unit is busy");
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("committed pose not presented");
`endif

endmodule
`default_nettype wire
